/* rtl/d8ssa_pkg.sv */
// shared constants, tables and types for the d8 steepest slope and aspect block
package d8ssa_pkg;

    localparam int ELEV_WIDTH_DEF = 24;
    localparam int INV_WIDTH      = 24;
    localparam logic [INV_WIDTH-1:0] INV_RESET = 24'd65536;
    localparam int NDIR           = 8;
    localparam int IDX_WIDTH      = 3;
    localparam int K_WIDTH        = 30;
    localparam logic [K_WIDTH-1:0] DIAG_K = 30'd759250125;
    localparam int CORDIC_STEPS   = 23;
    localparam int ZW             = 25;
    localparam int NORM_BIT       = 40;
    localparam int SH_WIDTH       = 5;
    localparam int SLOPE_WIDTH    = 15;
    localparam logic [SLOPE_WIDTH-1:0] SLOPE_MAX = 15'd23040;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
        25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115,
        25'sd57, 25'sd29, 25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1
    };

    typedef struct packed {
        logic                 found;
        logic [IDX_WIDTH-1:0] idx;
    } cand_t;

endpackage

/* rtl/d8ssa_lane.sv */
// one gradient lane: drop, scale by reciprocal cell size, optional diagonal scale
module d8ssa_lane
    import d8ssa_pkg::*;
#(
    parameter int ELEV_WIDTH = ELEV_WIDTH_DEF,
    parameter bit DIAG       = 1'b0,
    parameter int GW         = ELEV_WIDTH + INV_WIDTH
)
(
    input  logic                         clk,
    input  logic signed [ELEV_WIDTH-1:0] center,
    input  logic signed [ELEV_WIDTH-1:0] neigh,
    input  logic                         present,
    input  logic [INV_WIDTH-1:0]         inv,
    output logic [GW-1:0]                grad,
    output logic                         cand
);

    logic signed [ELEV_WIDTH:0] drop;
    logic [GW-1:0] g1_reg;
    logic          ok1_reg;
    logic          ok2_reg;

    assign drop = {center[ELEV_WIDTH-1], center} - {neigh[ELEV_WIDTH-1], neigh};

    always_ff @(posedge clk)
    begin
        g1_reg  <= drop[ELEV_WIDTH-1:0] * inv;
        ok1_reg <= present && !drop[ELEV_WIDTH] && (drop != '0);
        ok2_reg <= ok1_reg;
    end

    generate
        if (DIAG)
        begin : g_diag
            logic [GW-INV_WIDTH+K_WIDTH-1:0] a_reg;
            logic [INV_WIDTH+K_WIDTH-1:0]    b_reg;
            logic [INV_WIDTH+K_WIDTH:0]      low_sum;
            logic [GW:0]                     g_next;
            logic [GW-1:0]                   g3_reg;
            logic                            ok3_reg;

            always_ff @(posedge clk)
            begin
                a_reg   <= g1_reg[GW-1:INV_WIDTH] * DIAG_K;
                b_reg   <= g1_reg[INV_WIDTH-1:0] * DIAG_K;
                g3_reg  <= g_next[GW-1:0];
                ok3_reg <= ok2_reg;
            end

            always_comb
            begin
                low_sum = {1'b0, a_reg[5:0], {INV_WIDTH{1'b0}}} + {1'b0, b_reg};
                g_next  = (GW+1)'(a_reg >> 6) + (GW+1)'(low_sum >> K_WIDTH);
            end

            assign grad = g3_reg;
            assign cand = ok3_reg && (g3_reg != '0);
        end
        else
        begin : g_orth
            logic [GW-1:0] g2_reg;
            logic [GW-1:0] g3_reg;
            logic          ok3_reg;

            always_ff @(posedge clk)
            begin
                g2_reg  <= g1_reg;
                g3_reg  <= g2_reg;
                ok3_reg <= ok2_reg;
            end

            assign grad = g3_reg;
            assign cand = ok3_reg && (g3_reg != '0);
        end
    endgenerate

endmodule

/* rtl/d8ssa_merge.sv */
// registered three-level tree picking the steepest lane, lowest index on ties
module d8ssa_merge
    import d8ssa_pkg::*;
#(
    parameter int GW = ELEV_WIDTH_DEF + INV_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [GW-1:0] grad [NDIR],
    input  logic          cand [NDIR],
    output logic          out_valid,
    output logic [GW-1:0] best_grad,
    output cand_t         best
);

    logic [GW-1:0] l1_g_reg [4];
    cand_t         l1_c_reg [4];
    logic [GW-1:0] l2_g_reg [2];
    cand_t         l2_c_reg [2];
    logic [GW-1:0] l3_g_reg;
    cand_t         l3_c_reg;
    logic [2:0]    valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cand[2*i+1] && (!cand[2*i] || grad[2*i+1] > grad[2*i]))
            begin
                l1_g_reg[i] <= grad[2*i+1];
                l1_c_reg[i] <= '{found: 1'b1, idx: IDX_WIDTH'(2*i+1)};
            end
            else
            begin
                l1_g_reg[i] <= grad[2*i];
                l1_c_reg[i] <= '{found: cand[2*i], idx: IDX_WIDTH'(2*i)};
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (l1_c_reg[2*i+1].found
                && (!l1_c_reg[2*i].found || l1_g_reg[2*i+1] > l1_g_reg[2*i]))
            begin
                l2_g_reg[i] <= l1_g_reg[2*i+1];
                l2_c_reg[i] <= l1_c_reg[2*i+1];
            end
            else
            begin
                l2_g_reg[i] <= l1_g_reg[2*i];
                l2_c_reg[i] <= l1_c_reg[2*i];
            end
        end
        if (l2_c_reg[1].found && (!l2_c_reg[0].found || l2_g_reg[1] > l2_g_reg[0]))
        begin
            l3_g_reg <= l2_g_reg[1];
            l3_c_reg <= l2_c_reg[1];
        end
        else
        begin
            l3_g_reg <= l2_g_reg[0];
            l3_c_reg <= l2_c_reg[0];
        end
    end

    assign out_valid = valid_reg[2];
    assign best_grad = l3_g_reg;
    assign best      = l3_c_reg;

endmodule

/* rtl/d8ssa_cordic.sv */
// normalize, pipelined vectoring cordic for atan of the gradient, round and clamp
module d8ssa_cordic
    import d8ssa_pkg::*;
#(
    parameter int GW = ELEV_WIDTH_DEF + INV_WIDTH,
    parameter int XW = ((GW > NORM_BIT + 1) ? GW : NORM_BIT + 1) + 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [GW-1:0]          grad,
    input  cand_t                  info,
    output logic                   done,
    output logic                   result_valid,
    output logic [SLOPE_WIDTH-1:0] slope_deg,
    output logic [IDX_WIDTH-1:0]   aspect_index
);

    // shift search
    logic [GW+NORM_BIT:0] gx;
    logic [NORM_BIT:0]    m;
    logic                 big;
    logic [SH_WIDTH-1:0]  sh;

    logic [GW-1:0]       n1_g_reg;
    logic [SH_WIDTH-1:0] n1_sh_reg;
    cand_t               n1_c_reg;
    logic                n1_v_reg;

    always_comb
    begin
        gx  = {{(NORM_BIT+1){1'b0}}, grad};
        big = (gx[GW+NORM_BIT:NORM_BIT] != '0);
        m   = (gx[NORM_BIT:0] > (NORM_BIT+1)'(65536)) ? gx[NORM_BIT:0]
                                                      : (NORM_BIT+1)'(65536);
        sh  = '0;
        for (int b = 16; b < NORM_BIT; b++)
        begin
            if (m[b])
                sh = SH_WIDTH'(NORM_BIT - b);
        end
        if (big)
            sh = '0;
    end

    always_ff @(posedge clk)
    begin
        n1_g_reg  <= grad;
        n1_sh_reg <= sh;
        n1_c_reg  <= info;
    end

    logic signed [XW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    cand_t                c_reg [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] v_reg;

    always_ff @(posedge clk)
    begin
        x_reg[0] <= $signed({{(XW-17){1'b0}}, 17'h10000} << n1_sh_reg);
        y_reg[0] <= $signed({{(XW-GW){1'b0}}, n1_g_reg} << n1_sh_reg);
        z_reg[0] <= '0;
        c_reg[0] <= n1_c_reg;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            c_reg[i+1] <= c_reg[i];
            if (!y_reg[i][XW-1])
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
            end
        end
    end

    logic signed [ZW-1:0] zc;
    logic [ZW-1:0]        zsum;
    logic [ZW-9:0]        zr;
    logic [SLOPE_WIDTH-1:0] slope_next;

    always_comb
    begin
        zc   = z_reg[CORDIC_STEPS][ZW-1] ? '0 : z_reg[CORDIC_STEPS];
        zsum = zc + ZW'(128);
        zr   = zsum[ZW-1:8];
        slope_next = (zr > (ZW-8)'(SLOPE_MAX)) ? SLOPE_MAX : zr[SLOPE_WIDTH-1:0];
    end

    logic                   done_reg;
    logic                   rv_reg;
    logic [SLOPE_WIDTH-1:0] slope_reg;
    logic [IDX_WIDTH-1:0]   idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_v_reg <= 1'b0;
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            n1_v_reg <= in_valid;
            v_reg    <= {v_reg[CORDIC_STEPS-1:0], n1_v_reg};
            done_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg    <= c_reg[CORDIC_STEPS].found;
        slope_reg <= c_reg[CORDIC_STEPS].found ? slope_next : '0;
        idx_reg   <= c_reg[CORDIC_STEPS].found ? c_reg[CORDIC_STEPS].idx : '0;
    end

    assign done         = done_reg;
    assign result_valid = rv_reg;
    assign slope_deg    = slope_reg;
    assign aspect_index = idx_reg;

endmodule

/* rtl/d8_steepest_slope_aspect.sv */
// top level of the d8 steepest descent slope and aspect block
// usage:
//   raise start with one 3x3 window on center_elev, elev_n..elev_nw and
//   present_mask; the window is taken at any edge with start high and busy
//   low. busy stays low, so a window can be offered every cycle.
//   inv_cellsize is written through cfg_valid/cfg_ready/cfg_data, one beat
//   per write; the user must do so only while no window is in flight, as
//   the block does not enforce it; cfg_ready is always high.
//   each window gives one result beat: done is high for one cycle with
//   result_valid, slope_deg and aspect_index. a window passes the gradient
//   lanes (multiply, diagonal multiply or delay, combine), the merge tree,
//   the normalizing shift, 23 cordic stages and round and clamp.
//   throughput is one window per cycle; every stage is fully pipelined.
//   the receiver cannot stall: results must be taken when done is high.
//   reset clears the pipeline, drops windows in flight and sets
//   inv_cellsize to 1.0 (65536 in q8.16).
module d8_steepest_slope_aspect
    import d8ssa_pkg::*;
#(
    parameter int ELEV_WIDTH = ELEV_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEV_WIDTH-1:0] center_elev,
    input  logic signed [ELEV_WIDTH-1:0] elev_n,
    input  logic signed [ELEV_WIDTH-1:0] elev_ne,
    input  logic signed [ELEV_WIDTH-1:0] elev_e,
    input  logic signed [ELEV_WIDTH-1:0] elev_se,
    input  logic signed [ELEV_WIDTH-1:0] elev_s,
    input  logic signed [ELEV_WIDTH-1:0] elev_sw,
    input  logic signed [ELEV_WIDTH-1:0] elev_w,
    input  logic signed [ELEV_WIDTH-1:0] elev_nw,
    input  logic [8:0]                   present_mask,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [INV_WIDTH-1:0]         cfg_data,
    output logic                         done,
    output logic                         result_valid,
    output logic [SLOPE_WIDTH-1:0]       slope_deg,
    output logic [IDX_WIDTH-1:0]         aspect_index
);

    localparam int GW = ELEV_WIDTH + INV_WIDTH;

    logic [INV_WIDTH-1:0] inv_reg;
    logic [2:0]           valid_reg;
    logic signed [ELEV_WIDTH-1:0] neigh [NDIR];
    logic [GW-1:0]        grad [NDIR];
    logic                 cand [NDIR];
    logic                 m_valid;
    logic [GW-1:0]        m_grad;
    cand_t                m_best;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign neigh[0] = elev_n;
    assign neigh[1] = elev_ne;
    assign neigh[2] = elev_e;
    assign neigh[3] = elev_se;
    assign neigh[4] = elev_s;
    assign neigh[5] = elev_sw;
    assign neigh[6] = elev_w;
    assign neigh[7] = elev_nw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg   <= INV_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                inv_reg <= cfg_data;
            valid_reg <= {valid_reg[1:0], start && !busy};
        end
    end

    generate
        for (genvar i = 0; i < NDIR; i++)
        begin : g_lane
            d8ssa_lane #(
                .ELEV_WIDTH (ELEV_WIDTH),
                .DIAG       (i % 2 == 1),
                .GW         (GW)
            ) u_lane (
                .clk     (clk),
                .center  (center_elev),
                .neigh   (neigh[i]),
                .present (present_mask[i] && present_mask[8]),
                .inv     (inv_reg),
                .grad    (grad[i]),
                .cand    (cand[i])
            );
        end
    endgenerate

    d8ssa_merge #(
        .GW (GW)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[2]),
        .grad      (grad),
        .cand      (cand),
        .out_valid (m_valid),
        .best_grad (m_grad),
        .best      (m_best)
    );

    d8ssa_cordic #(
        .GW (GW)
    ) u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (m_valid),
        .grad         (m_grad),
        .info         (m_best),
        .done         (done),
        .result_valid (result_valid),
        .slope_deg    (slope_deg),
        .aspect_index (aspect_index)
    );

endmodule

/* verif/tb.sv */
// testbench for the d8 steepest slope and aspect block with scoreboard and stimulus
`timescale 1ns / 1ps

module tb;
    import d8ssa_pkg::*;

    localparam int EW        = ELEV_WIDTH_DEF;
    localparam int LIMIT     = 300000;
    localparam int TAIL      = 40;

    typedef struct {
        logic signed [EW-1:0] center;
        logic signed [EW-1:0] nb [NDIR];
        logic [8:0]           mask;
    } window_t;

    typedef struct {
        logic                   ok;
        logic [SLOPE_WIDTH-1:0] slope;
        logic [IDX_WIDTH-1:0]   aspect;
    } slope_aspect_t;

    class slope_board;
        slope_aspect_t    pending [$];
        logic [INV_WIDTH-1:0] inv_cell;
        int               errors;

        function new();
            inv_cell = INV_RESET;
            errors   = 0;
        endfunction

        function logic [SLOPE_WIDTH-1:0] atan_deg(logic [63:0] grad);
            longint ux;
            longint uy;
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            ux = longint'(65536);
            uy = grad;
            z  = 0;
            while (ux < (64'd1 << NORM_BIT) && uy < (64'd1 << NORM_BIT))
            begin
                ux = ux << 1;
                uy = uy << 1;
            end
            x = ux;
            y = uy;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_TAB[i]);
                end
            end
            if (z < 0)
                z = 0;
            z = (z + 128) >>> 8;
            if (z > longint'(SLOPE_MAX))
                z = longint'(SLOPE_MAX);
            return z[SLOPE_WIDTH-1:0];
        endfunction

        function void note_window(window_t w);
            slope_aspect_t r;
            logic [127:0]  g;
            logic [127:0]  best;
            longint        drop;
            int            best_i;
            r      = '{ok: 1'b0, slope: '0, aspect: '0};
            best   = '0;
            best_i = -1;
            if (w.mask[8])
            begin
                for (int i = 0; i < NDIR; i++)
                begin
                    if (!w.mask[i])
                        continue;
                    drop = longint'(w.center) - longint'(w.nb[i]);
                    if (drop <= 0)
                        continue;
                    g = 128'(drop) * 128'(inv_cell);
                    if (i % 2 == 1)
                        g = (g * 128'(DIAG_K)) >> 30;
                    if (g > 0 && (best_i < 0 || g > best))
                    begin
                        best   = g;
                        best_i = i;
                    end
                end
                if (best_i >= 0)
                begin
                    r.ok     = 1'b1;
                    r.slope  = atan_deg(best[63:0]);
                    r.aspect = best_i[IDX_WIDTH-1:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic ok, logic [SLOPE_WIDTH-1:0] slope,
                                   logic [IDX_WIDTH-1:0] aspect);
            slope_aspect_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok)
            begin
                $error("result_valid expected %0d actual %0d", e.ok, ok);
                errors++;
            end
            if (slope !== e.slope)
            begin
                $error("slope_deg expected %0d actual %0d", e.slope, slope);
                errors++;
            end
            if (aspect !== e.aspect)
            begin
                $error("aspect_index expected %0d actual %0d", e.aspect, aspect);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [EW-1:0]   center_elev = '0;
    logic signed [EW-1:0]   elev [NDIR];
    logic [8:0]             present_mask = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [INV_WIDTH-1:0]   cfg_data = '0;
    logic                   done;
    logic                   result_valid;
    logic [SLOPE_WIDTH-1:0] slope_deg;
    logic [IDX_WIDTH-1:0]   aspect_index;

    logic                   busy_s;
    logic                   ready_s;
    int                     cycles = 0;
    slope_board             sb = new();

    initial
    begin
        for (int i = 0; i < NDIR; i++)
            elev[i] = '0;
    end

    always #5 clk = ~clk;

    d8_steepest_slope_aspect dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .center_elev  (center_elev),
        .elev_n       (elev[0]),
        .elev_ne      (elev[1]),
        .elev_e       (elev[2]),
        .elev_se      (elev[3]),
        .elev_s       (elev[4]),
        .elev_sw      (elev[5]),
        .elev_w       (elev[6]),
        .elev_nw      (elev[7]),
        .present_mask (present_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .result_valid (result_valid),
        .slope_deg    (slope_deg),
        .aspect_index (aspect_index)
    );

    always @(negedge clk)
    begin
        busy_s  <= busy;
        ready_s <= cfg_ready;
        if (rst_n && done)
            sb.check_result(result_valid, slope_deg, aspect_index);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_window(window_t w);
        start        <= 1'b1;
        center_elev  <= w.center;
        present_mask <= w.mask;
        for (int i = 0; i < NDIR; i++)
            elev[i] <= w.nb[i];
        do
            @(posedge clk);
        while (busy_s);
        sb.note_window(w);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_inv(logic [INV_WIDTH-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!ready_s);
        cfg_valid <= 1'b0;
        sb.inv_cell = v;
        @(posedge clk);
    endtask

    function automatic window_t flat_window(int c, logic [8:0] m);
        window_t w;
        w.center = EW'(c);
        w.mask   = m;
        for (int i = 0; i < NDIR; i++)
            w.nb[i] = EW'(c);
        return w;
    endfunction

    function automatic window_t random_window();
        window_t w;
        int      spread;
        w.center = EW'($urandom);
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 4;
            2: spread = 4000;
            default: spread = 1 << 22;
        endcase
        for (int i = 0; i < NDIR; i++)
        begin
            if (spread == 0 || $urandom_range(0, 9) == 0)
                w.nb[i] = EW'($urandom);
            else
                w.nb[i] = EW'(w.center + $signed($urandom_range(0, 2 * spread)) - spread);
        end
        if ($urandom_range(0, 7) == 0)
            w.mask = 9'($urandom);
        else
            w.mask = {1'b1, 8'($urandom)};
        return w;
    endfunction

    task automatic directed_set();
        window_t w;
        send_window(flat_window(0, 9'h000));
        w = flat_window(100, 9'h0ff);
        w.nb[0] = EW'(-5);
        send_window(w);
        send_window(flat_window(7, 9'h1ff));
        w = flat_window(-8388608, 9'h1ff);
        w.nb[3] = EW'(8388607);
        send_window(w);
        w = flat_window(8388607, 9'h1ff);
        w.nb[5] = EW'(-8388608);
        send_window(w);
        w = flat_window(8388607, 9'h1ff);
        for (int i = 0; i < NDIR; i++)
            w.nb[i] = EW'(-8388608);
        send_window(w);
        w = flat_window(50, 9'h1ff);
        w.nb[2] = EW'(40);
        w.nb[6] = EW'(40);
        send_window(w);
        w = flat_window(50, 9'h1ff);
        w.nb[1] = EW'(30);
        w.nb[4] = EW'(40);
        send_window(w);
        w = flat_window(1, 9'h1aa);
        w.nb[1] = EW'(0);
        w.nb[7] = EW'(0);
        send_window(w);
        w = flat_window(1000, 9'h155);
        for (int i = 0; i < NDIR; i++)
            w.nb[i] = EW'(1000 - 10 * (i + 1));
        send_window(w);
        w = flat_window(0, 9'h1ff);
        w.nb[7] = EW'(-1);
        send_window(w);
        w = flat_window(-1, 9'h1ff);
        w.nb[0] = EW'(-8388608);
        w.nb[4] = EW'(-8388608);
        send_window(w);
        w = flat_window(3, 9'h100);
        w.nb[2] = EW'(0);
        send_window(w);
        pause(1);
    endtask

    task automatic random_run(int n);
        int left;
        int burst;
        int gap_max;
        left = n;
        gap_max = $urandom_range(0, 1) ? 0 : 6;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                send_window(random_window());
                burst--;
                left--;
            end
            if (gap_max > 0 && $urandom_range(0, 2) != 0)
                pause($urandom_range(1, gap_max));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_set();
        random_run(200);
        drain();
        write_inv(24'd1);
        directed_set();
        random_run(120);
        drain();
        write_inv(24'hffffff);
        directed_set();
        random_run(150);
        drain();
        write_inv(24'd0);
        random_run(40);
        drain();
        write_inv(24'd256);
        random_run(120);
        drain();
        write_inv(24'($urandom));
        random_run(150);
        drain();
        write_inv(INV_RESET);
        random_run(200);
        drain();
        repeat (TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
